@@ hw/rtl/ifs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifs_pkg: shared types and constants for the integer field scanner
// Character codes, base and size codes, the configuration bundle and the
// finished-field record passed from the scan stage to the format stage.
// ----------------------------------------------------------------------------
package ifs_pkg;

  // Field width cap and counter sizing
  localparam int MAX_FIELD_CHARS = 63;
  localparam int MAXW_W          = 6;
  localparam int CNT_W           = $clog2(MAX_FIELD_CHARS + 1);
  localparam int CMP_W           = ((CNT_W > MAXW_W) ? CNT_W : MAXW_W) + 1;

  localparam int VAL_W = 64;
  localparam int SUM_W = VAL_W + 4;

  // Base codes (register and active base)
  localparam logic [1:0] BASE_AUTO = 2'd0;
  localparam logic [1:0] BASE_OCT  = 2'd1;
  localparam logic [1:0] BASE_DEC  = 2'd2;
  localparam logic [1:0] BASE_HEX  = 2'd3;

  // Store size codes
  localparam logic [1:0] SZ_BYTE  = 2'd0;
  localparam logic [1:0] SZ_HALF  = 2'd1;
  localparam logic [1:0] SZ_WORD  = 2'd2;
  localparam logic [1:0] SZ_DWORD = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_MATCH = 2'd1;
  localparam logic [1:0] ST_EOI      = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_BASE_MODE   = 2'd0;
  localparam logic [1:0] REG_SIGNED_MODE = 2'd1;
  localparam logic [1:0] REG_MAX_WIDTH   = 2'd2;
  localparam logic [1:0] REG_STORE_SIZE  = 2'd3;

  // Character codes
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_F_UP  = 8'h46;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_F_LO  = 8'h66;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_X_LO  = 8'h78;

  localparam logic [VAL_W-1:0] SAT_POS = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] SAT_NEG = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct packed {
    logic [1:0]        base_mode;
    logic              signed_mode;
    logic [MAXW_W-1:0] max_width;
    logic [1:0]        store_size;
  } cfg_t;

  // Finished field, as handed to the formatter
  typedef struct packed {
    logic [VAL_W-1:0] acc;
    logic             neg;
    logic             ovf;
    logic [1:0]       status;
    logic             consumed;
    logic             signed_mode;
    logic [1:0]       store_size;
  } fin_rec_t;

  // Hex digit decode: {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      r = {1'b1, 4'(c - CH_ZERO)};
    end else if (c >= CH_A_LO && c <= CH_F_LO) begin
      r = {1'b1, 4'(c - CH_A_LO + 8'd10)};
    end else if (c >= CH_A_UP && c <= CH_F_UP) begin
      r = {1'b1, 4'(c - CH_A_UP + 8'd10)};
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/ifs_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifs_scan: per-character scan step
// Holds the field state (phase, accumulator, flags, count), advances it by
// one character per accepted transaction and registers a record of each
// finished field for the formatter.
// ----------------------------------------------------------------------------
module ifs_scan (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_take,
  input  logic [7:0]        char_in,
  input  logic              end_of_input,
  input  ifs_pkg::cfg_t     cfg,
  input  logic              fmt_ready,
  output logic              rec_ready,
  output logic              rec_valid,
  output ifs_pkg::fin_rec_t rec
);

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_FIRST,
    PH_ZERO,
    PH_DIGITS
  } phase_t;

  phase_t                          phase_r, phase_nxt;
  logic [ifs_pkg::VAL_W-1:0]       acc_r, acc_nxt;
  logic                            neg_r, neg_nxt;
  logic [ifs_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                            ovf_r, ovf_nxt;
  logic                            ds_r, ds_nxt;
  logic [1:0]                      ab_r, ab_nxt;
  logic                            rec_valid_r;
  ifs_pkg::fin_rec_t               rec_r;

  logic                            fin;
  logic [1:0]                      fin_st;
  logic                            fin_cons;
  logic                            is_space, is_sign;
  logic [1:0]                      ab_dig;
  logic [4:0]                      hd;
  logic                            dig_ok;
  logic [ifs_pkg::SUM_W-1:0]       mul, sum;
  logic                            sum_ovf;
  logic [ifs_pkg::CMP_W-1:0]       mw_ext, lim, cnt_inc;
  logic                            hit;

  // Character class and count limit
  assign is_space = (char_in == ifs_pkg::CH_SPACE) ||
                    (char_in >= ifs_pkg::CH_TAB && char_in <= ifs_pkg::CH_CR);
  assign is_sign  = (char_in == ifs_pkg::CH_PLUS) || (char_in == ifs_pkg::CH_MINUS);
  assign mw_ext   = ifs_pkg::CMP_W'(cfg.max_width);
  assign lim      = (mw_ext == '0 || mw_ext > ifs_pkg::CMP_W'(ifs_pkg::MAX_FIELD_CHARS)) ?
                    ifs_pkg::CMP_W'(ifs_pkg::MAX_FIELD_CHARS) : mw_ext;
  assign cnt_inc  = ifs_pkg::CMP_W'(cnt_r) + ifs_pkg::CMP_W'(1);
  assign hit      = cnt_inc >= lim;

  // Base used for a digit in this step (latched at the first non-space)
  assign ab_dig = (phase_r == PH_SKIP) ?
                  ((cfg.base_mode == ifs_pkg::BASE_AUTO) ? ifs_pkg::BASE_DEC : cfg.base_mode) :
                  ab_r;

  // Digit decode in the active base
  always_comb begin
    hd     = ifs_pkg::hex_digit(char_in);
    dig_ok = hd[4];
    case (ab_dig)
      ifs_pkg::BASE_OCT: dig_ok = hd[4] && (hd[3:0] <= 4'd7);
      ifs_pkg::BASE_HEX: dig_ok = hd[4];
      default:           dig_ok = hd[4] && (hd[3:0] <= 4'd9);
    endcase
  end

  // Accumulate: acc * base + digit, overflow when it leaves 64 bits
  always_comb begin
    case (ab_dig)
      ifs_pkg::BASE_OCT: mul = {1'b0, acc_r, 3'b000};
      ifs_pkg::BASE_HEX: mul = {acc_r, 4'b0000};
      default:           mul = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0};
    endcase
    sum     = mul + ifs_pkg::SUM_W'(hd[3:0]);
    sum_ovf = |sum[ifs_pkg::SUM_W-1:ifs_pkg::VAL_W];
  end

  // One scan step
  always_comb begin
    logic done;
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    ds_nxt    = ds_r;
    ab_nxt    = ab_r;
    fin       = 1'b0;
    fin_st    = ifs_pkg::ST_OK;
    fin_cons  = 1'b0;
    done      = 1'b0;

    if (phase_r == PH_SKIP) begin
      if (end_of_input) begin
        fin    = 1'b1;
        fin_st = ifs_pkg::ST_EOI;
        done   = 1'b1;
      end else if (is_space) begin
        done = 1'b1;
      end else begin
        ab_nxt    = ab_dig;
        phase_nxt = PH_FIRST;
        if (is_sign) begin
          neg_nxt  = (char_in == ifs_pkg::CH_MINUS);
          cnt_nxt  = cnt_inc[ifs_pkg::CNT_W-1:0];
          fin      = hit;
          fin_cons = 1'b1;
          done     = 1'b1;
        end
      end
    end

    if (!done && end_of_input) begin
      fin  = 1'b1;
      done = 1'b1;
    end

    if (!done) begin
      if (phase_r == PH_SKIP || phase_r == PH_FIRST) begin
        // a leading zero is a prefix in auto and hex modes
        if (char_in == ifs_pkg::CH_ZERO &&
            (cfg.base_mode == ifs_pkg::BASE_AUTO || cfg.base_mode == ifs_pkg::BASE_HEX)) begin
          if (cfg.base_mode == ifs_pkg::BASE_AUTO) begin
            ab_nxt = ifs_pkg::BASE_OCT;
          end
          ds_nxt    = 1'b1;
          phase_nxt = PH_ZERO;
          cnt_nxt   = cnt_inc[ifs_pkg::CNT_W-1:0];
          fin       = hit;
          fin_cons  = 1'b1;
          done      = 1'b1;
        end else begin
          phase_nxt = PH_DIGITS;
        end
      end else if (phase_r == PH_ZERO) begin
        phase_nxt = PH_DIGITS;
        if (char_in == ifs_pkg::CH_X_LO || char_in == ifs_pkg::CH_X_UP) begin
          ab_nxt   = ifs_pkg::BASE_HEX;
          cnt_nxt  = cnt_inc[ifs_pkg::CNT_W-1:0];
          fin      = hit;
          fin_cons = 1'b1;
          done     = 1'b1;
        end
      end
    end

    if (!done) begin
      if (!dig_ok) begin
        fin = 1'b1;
      end else begin
        ds_nxt = 1'b1;
        if (!ovf_r) begin
          if (sum_ovf) begin
            ovf_nxt = 1'b1;
          end else begin
            acc_nxt = sum[ifs_pkg::VAL_W-1:0];
          end
        end
        cnt_nxt  = cnt_inc[ifs_pkg::CNT_W-1:0];
        fin      = hit;
        fin_cons = 1'b1;
      end
    end

    if (fin && fin_st == ifs_pkg::ST_OK && !ds_nxt) begin
      fin_st = ifs_pkg::ST_NO_MATCH;
    end
  end

  assign rec_ready = !rec_valid_r || fmt_ready;

  // Field state and finished-field record
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SKIP;
      acc_r       <= '0;
      neg_r       <= 1'b0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      ds_r        <= 1'b0;
      ab_r        <= ifs_pkg::BASE_DEC;
      rec_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        if (fin) begin
          phase_r <= PH_SKIP;
          acc_r   <= '0;
          neg_r   <= 1'b0;
          cnt_r   <= '0;
          ovf_r   <= 1'b0;
          ds_r    <= 1'b0;
          ab_r    <= ifs_pkg::BASE_DEC;
        end else begin
          phase_r <= phase_nxt;
          acc_r   <= acc_nxt;
          neg_r   <= neg_nxt;
          cnt_r   <= cnt_nxt;
          ovf_r   <= ovf_nxt;
          ds_r    <= ds_nxt;
          ab_r    <= ab_nxt;
        end
      end
      if (rec_ready) begin
        rec_valid_r <= in_take && fin;
      end
      // record payload
      if (rec_ready && in_take && fin) begin
        rec_r.acc         <= acc_nxt;
        rec_r.neg         <= neg_nxt;
        rec_r.ovf         <= ovf_nxt;
        rec_r.status      <= fin_st;
        rec_r.consumed    <= fin_cons;
        rec_r.signed_mode <= cfg.signed_mode;
        rec_r.store_size  <= cfg.store_size;
      end
    end
  end

  assign rec_valid = rec_valid_r;
  assign rec       = rec_r;

endmodule

@@ hw/rtl/ifs_format.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifs_format: result conversion and output register
// Applies sign, saturation and store-size truncation to a finished field and
// holds the result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module ifs_format (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rec_valid,
  input  ifs_pkg::fin_rec_t         rec,
  output logic                      fmt_ready,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ifs_pkg::VAL_W-1:0] out_value,
  output logic [1:0]                out_status,
  output logic                      out_char_consumed
);

  logic                      out_valid_r;
  logic [ifs_pkg::VAL_W-1:0] value_r, value_nxt;
  logic [1:0]                status_r;
  logic                      consumed_r;
  logic [ifs_pkg::VAL_W-1:0] neg_acc, v;
  logic                      sat;

  assign neg_acc   = ifs_pkg::VAL_W'(0) - rec.acc;
  assign fmt_ready = !out_valid_r || !out_stall;

  // Sign, saturation and truncation
  always_comb begin
    sat = 1'b0;
    if (rec.signed_mode) begin
      if (!rec.neg) begin
        sat = rec.ovf || rec.acc[ifs_pkg::VAL_W-1];
        v   = sat ? ifs_pkg::SAT_POS : rec.acc;
      end else begin
        sat = rec.ovf || (rec.acc[ifs_pkg::VAL_W-1] && |rec.acc[ifs_pkg::VAL_W-2:0]);
        v   = sat ? ifs_pkg::SAT_NEG : neg_acc;
      end
    end else begin
      if (rec.ovf) begin
        v = '1;
      end else begin
        v = rec.neg ? neg_acc : rec.acc;
      end
    end

    case (rec.store_size)
      ifs_pkg::SZ_BYTE: value_nxt = {{56{v[7]}}, v[7:0]};
      ifs_pkg::SZ_HALF: value_nxt = {{48{v[15]}}, v[15:0]};
      ifs_pkg::SZ_WORD: value_nxt = {{32{v[31]}}, v[31:0]};
      default:          value_nxt = v;
    endcase

    if (rec.status != ifs_pkg::ST_OK) begin
      value_nxt = '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fmt_ready) begin
      out_valid_r <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fmt_ready && rec_valid) begin
      value_r    <= value_nxt;
      status_r   <= rec.status;
      consumed_r <= rec.consumed;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_value         = value_r;
  assign out_status        = status_r;
  assign out_char_consumed = consumed_r;

endmodule

@@ hw/rtl/integer_field_scanner.sv @@
`timescale 1ns / 1ps
// Pipeline: the transaction that ends a field writes the field record in the scan stage,
//   and conversion then writes the output register; either register can hold under a stall.
// Throughput: one character per cycle while in_stall is low.
// Reset (synchronous, rst_n low): scan state returns to skipping whitespace, the
//   pipeline empties, and registers load base decimal, signed, width cap, four bytes.
// ----------------------------------------------------------------------------
// integer_field_scanner: scanf-style integer field conversion
// Top level: configuration registers, input handshake, scan stage and
// format/output stage.
// ----------------------------------------------------------------------------
module integer_field_scanner (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_in,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_value,
  output logic [1:0]  out_status,
  output logic        out_char_consumed,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);

  logic [1:0]                 base_mode_r;
  logic                       signed_mode_r;
  logic [ifs_pkg::MAXW_W-1:0] max_width_r;
  logic [1:0]                 store_size_r;
  ifs_pkg::cfg_t              cfg;
  logic                       rec_ready, rec_valid, fmt_ready, in_take;
  ifs_pkg::fin_rec_t          rec;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_mode_r   <= ifs_pkg::BASE_DEC;
      signed_mode_r <= 1'b1;
      max_width_r   <= '0;
      store_size_r  <= ifs_pkg::SZ_WORD;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ifs_pkg::REG_BASE_MODE:   base_mode_r   <= cfg_data[1:0];
        ifs_pkg::REG_SIGNED_MODE: signed_mode_r <= cfg_data[0];
        ifs_pkg::REG_MAX_WIDTH:   max_width_r   <= cfg_data[ifs_pkg::MAXW_W-1:0];
        ifs_pkg::REG_STORE_SIZE:  store_size_r  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign cfg.base_mode   = base_mode_r;
  assign cfg.signed_mode = signed_mode_r;
  assign cfg.max_width   = max_width_r;
  assign cfg.store_size  = store_size_r;

  // Input handshake
  assign in_stall = !rec_ready;
  assign in_take  = in_valid && !in_stall;

  ifs_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_take      (in_take),
    .char_in      (in_char_in),
    .end_of_input (in_end_of_input),
    .cfg          (cfg),
    .fmt_ready    (fmt_ready),
    .rec_ready    (rec_ready),
    .rec_valid    (rec_valid),
    .rec          (rec)
  );

  ifs_format u_format (
    .clk               (clk),
    .rst_n             (rst_n),
    .rec_valid         (rec_valid),
    .rec               (rec),
    .fmt_ready         (fmt_ready),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_value         (out_value),
    .out_status        (out_status),
    .out_char_consumed (out_char_consumed)
  );

endmodule

@@ tb/sv/integer_field_scanner_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_field_scanner_checker: scoreboard for the integer field scanner
// Watches the character, result and register channels. It tracks the
// scanner state and the registers, works out any result that an accepted
// character causes, and compares every result, field by field, with the
// oldest result still due.
// ----------------------------------------------------------------------------
module integer_field_scanner_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_char_in,
  input  logic        in_end_of_input,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] out_value,
  input  logic [1:0]  out_status,
  input  logic        out_char_consumed,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data,
  output int          pending_results,
  output int          mismatch_count
);

  typedef enum logic [1:0] {
    SCAN_SKIP,
    SCAN_FIRST,
    SCAN_ZERO,
    SCAN_DIGITS
  } scan_phase_t;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
    logic        consumed;
  } field_result_t;

  // Register copies
  logic [1:0]                 base_reg;
  logic                       signed_reg;
  logic [ifs_pkg::MAXW_W-1:0] width_reg;
  logic [1:0]                 size_reg;

  // Scan state of the field in progress
  scan_phase_t phase;
  logic [63:0] acc;
  logic        neg;
  int          char_count;
  logic        ovf;
  logic        seen_digit;
  logic [1:0]  radix_code;

  field_result_t field_results_due[$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic restart_field();
    phase      = SCAN_SKIP;
    acc        = '0;
    neg        = 1'b0;
    char_count = 0;
    ovf        = 1'b0;
    seen_digit = 1'b0;
    radix_code = ifs_pkg::BASE_DEC;
  endtask

  function automatic bit is_blank(input logic [7:0] c);
    return c == ifs_pkg::CH_SPACE || (c >= ifs_pkg::CH_TAB && c <= ifs_pkg::CH_CR);
  endfunction

  // Digit value in the given base, -1 when the byte is not such a digit
  function automatic int digit_value(input logic [7:0] c, input logic [1:0] radix);
    int d;
    d = -1;
    if (c >= ifs_pkg::CH_ZERO && c <= ifs_pkg::CH_NINE) d = int'(c - ifs_pkg::CH_ZERO);
    else if (c >= ifs_pkg::CH_A_LO && c <= ifs_pkg::CH_F_LO)
      d = int'(c - ifs_pkg::CH_A_LO) + 10;
    else if (c >= ifs_pkg::CH_A_UP && c <= ifs_pkg::CH_F_UP)
      d = int'(c - ifs_pkg::CH_A_UP) + 10;
    if (radix == ifs_pkg::BASE_OCT && d > 7) return -1;
    if (radix == ifs_pkg::BASE_DEC && d > 9) return -1;
    return d;
  endfunction

  // Counts a field character; true once the width limit is hit
  function automatic bit take_char();
    int limit;
    limit = (width_reg == 0) ? ifs_pkg::MAX_FIELD_CHARS : int'(width_reg);
    char_count++;
    return char_count >= limit;
  endfunction

  task automatic add_digit(input int d);
    logic [63:0] mult;
    mult = (radix_code == ifs_pkg::BASE_OCT) ? 64'd8 :
           ((radix_code == ifs_pkg::BASE_HEX) ? 64'd16 : 64'd10);
    seen_digit = 1'b1;
    if (ovf) return;
    if (acc > ({64{1'b1}} - 64'(d)) / mult) begin
      ovf = 1'b1;
      return;
    end
    acc = acc * mult + 64'(d);
  endtask

  // Converts the finished field and queues its result
  task automatic close_field(input logic [1:0] st_in, input logic consumed);
    logic [1:0]    st;
    logic [63:0]   v;
    field_result_t r;
    st = st_in;
    v  = '0;
    if (st == ifs_pkg::ST_OK && !seen_digit) st = ifs_pkg::ST_NO_MATCH;
    if (st == ifs_pkg::ST_OK) begin
      if (signed_reg) begin
        if (!neg) v = (ovf || acc > ifs_pkg::SAT_POS) ? ifs_pkg::SAT_POS : acc;
        else v = (ovf || acc > ifs_pkg::SAT_NEG) ? ifs_pkg::SAT_NEG : 64'd0 - acc;
      end else begin
        v = ovf ? {64{1'b1}} : (neg ? 64'd0 - acc : acc);
      end
      case (size_reg)
        ifs_pkg::SZ_BYTE: v = {{56{v[7]}}, v[7:0]};
        ifs_pkg::SZ_HALF: v = {{48{v[15]}}, v[15:0]};
        ifs_pkg::SZ_WORD: v = {{32{v[31]}}, v[31:0]};
        default: ;
      endcase
    end
    r.value    = v;
    r.status   = st;
    r.consumed = consumed;
    field_results_due.push_back(r);
    restart_field();
  endtask

  // One character (or end of input) through the scanner
  task automatic scan_char(input logic [7:0] c, input logic eoi);
    int d;
    if (phase == SCAN_SKIP) begin
      if (eoi) begin
        close_field(ifs_pkg::ST_EOI, 1'b0);
        return;
      end
      if (is_blank(c)) return;
      radix_code = (base_reg == ifs_pkg::BASE_AUTO) ? ifs_pkg::BASE_DEC : base_reg;
      phase = SCAN_FIRST;
      if (c == ifs_pkg::CH_PLUS || c == ifs_pkg::CH_MINUS) begin
        neg = (c == ifs_pkg::CH_MINUS);
        if (take_char()) close_field(ifs_pkg::ST_OK, 1'b1);
        return;
      end
    end
    if (eoi) begin
      close_field(ifs_pkg::ST_OK, 1'b0);
      return;
    end
    if (phase == SCAN_FIRST) begin
      if (c == ifs_pkg::CH_ZERO &&
          (base_reg == ifs_pkg::BASE_AUTO || base_reg == ifs_pkg::BASE_HEX)) begin
        if (base_reg == ifs_pkg::BASE_AUTO) radix_code = ifs_pkg::BASE_OCT;
        add_digit(0);
        phase = SCAN_ZERO;
        if (take_char()) close_field(ifs_pkg::ST_OK, 1'b1);
        return;
      end
      phase = SCAN_DIGITS;
    end else if (phase == SCAN_ZERO) begin
      phase = SCAN_DIGITS;
      if (c == ifs_pkg::CH_X_LO || c == ifs_pkg::CH_X_UP) begin
        radix_code = ifs_pkg::BASE_HEX;
        if (take_char()) close_field(ifs_pkg::ST_OK, 1'b1);
        return;
      end
    end
    d = digit_value(c, radix_code);
    if (d < 0) begin
      close_field(ifs_pkg::ST_OK, 1'b0);
      return;
    end
    add_digit(d);
    if (take_char()) close_field(ifs_pkg::ST_OK, 1'b1);
  endtask

  always @(posedge clk) begin
    field_result_t want;
    if (!rst_n) begin
      base_reg   = ifs_pkg::BASE_DEC;
      signed_reg = 1'b1;
      width_reg  = '0;
      size_reg   = ifs_pkg::SZ_WORD;
      restart_field();
      field_results_due.delete();
    end else begin
      // result transaction against the oldest due result
      if (out_valid && !out_stall) begin
        if (field_results_due.size() == 0) begin
          report_mismatch($sformatf("result with none due: value %h status %0d",
                                    out_value, out_status));
        end else begin
          want = field_results_due.pop_front();
          if (out_value !== want.value)
            report_mismatch($sformatf("value %h, expected %h", out_value, want.value));
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
          if (out_char_consumed !== want.consumed)
            report_mismatch($sformatf("char_consumed %0b, expected %0b",
                                      out_char_consumed, want.consumed));
        end
      end
      // character transaction, seen with the registers as they were
      if (in_valid && !in_stall) scan_char(in_char_in, in_end_of_input);
      // register write takes effect after this edge
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ifs_pkg::REG_BASE_MODE:   base_reg   = cfg_data[1:0];
          ifs_pkg::REG_SIGNED_MODE: signed_reg = cfg_data[0];
          ifs_pkg::REG_MAX_WIDTH:   width_reg  = cfg_data;
          ifs_pkg::REG_STORE_SIZE:  size_reg   = cfg_data[1:0];
          default: ;
        endcase
      end
    end
    pending_results <= field_results_due.size();
  end

endmodule

@@ tb/sv/integer_field_scanner_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_field_scanner_test: top of the integer field scanner testbench
// Drives short directed strings and then random fields and noise under a
// series of register settings, with bursty input and a stalling receiver.
// The checker beside the block predicts and compares; this top gives the
// verdict.
// ----------------------------------------------------------------------------
module integer_field_scanner_test;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_COUNT  = 12;
  localparam int PHASE_CHARS  = 80;
  localparam int HOLD_CYCLES  = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char_in = '0;
  logic        in_end_of_input = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_value;
  logic [1:0]  out_status;
  logic        out_char_consumed;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [5:0]  cfg_data = '0;

  int pending_results;
  int mismatch_count;
  int cycle_count = 0;
  int chars_sent = 0;
  int burst_left = 0;
  int hold_off_count = 0;
  logic [1:0] cur_base = ifs_pkg::BASE_DEC;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  integer_field_scanner uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_char_in        (in_char_in),
    .in_end_of_input   (in_end_of_input),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_value         (out_value),
    .out_status        (out_status),
    .out_char_consumed (out_char_consumed),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  integer_field_scanner_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_char_in        (in_char_in),
    .in_end_of_input   (in_end_of_input),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_value         (out_value),
    .out_status        (out_status),
    .out_char_consumed (out_char_consumed),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .pending_results   (pending_results),
    .mismatch_count    (mismatch_count)
  );

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver stall pattern; a hold-off request freezes it for a long stretch
  initial begin
    int hold_seen;
    int hold_left;
    int seg_left;
    int seg_mode;
    hold_seen = 0;
    hold_left = 0;
    seg_left  = 0;
    seg_mode  = 0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_off_count) begin
        hold_seen = hold_off_count;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 120);
          seg_mode = $urandom_range(0, 3);
        end
        seg_left--;
        case (seg_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // Offers one transaction and waits until it is taken; bursts with gaps
  task automatic offer_char(input logic [7:0] c, input logic eoi);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid        <= 1'b1;
    in_char_in      <= c;
    in_end_of_input <= eoi;
    do @(posedge clk); while (in_stall);
    burst_left--;
    chars_sent++;
  endtask

  task automatic offer_end();
    offer_char(8'($urandom), 1'b1);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) offer_char(s[i], 1'b0);
  endtask

  // Closes any open field and waits until every result has come back
  task automatic finish_phase();
    offer_end();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic [1:0] base, input logic sgn,
                            input logic [5:0] width, input logic [1:0] size);
    write_reg(ifs_pkg::REG_BASE_MODE, {4'd0, base});
    write_reg(ifs_pkg::REG_SIGNED_MODE, {5'd0, sgn});
    write_reg(ifs_pkg::REG_MAX_WIDTH, width);
    write_reg(ifs_pkg::REG_STORE_SIZE, {4'd0, size});
    cfg_valid <= 1'b0;
    cur_base = base;
  endtask

  function automatic logic [7:0] pick_blank();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? ifs_pkg::CH_SPACE : ifs_pkg::CH_TAB + 8'(k);
  endfunction

  // Mostly a digit of the base, now and then one of a wider base
  function automatic logic [7:0] pick_digit(input logic [1:0] radix);
    int v;
    case (radix)
      ifs_pkg::BASE_OCT: v = $urandom_range(0, 7);
      ifs_pkg::BASE_HEX: v = $urandom_range(0, 15);
      default:           v = $urandom_range(0, 9);
    endcase
    if ($urandom_range(0, 11) == 0) v = $urandom_range(0, 15);
    if (v < 10) return ifs_pkg::CH_ZERO + 8'(v);
    return (($urandom_range(0, 1) != 0) ? ifs_pkg::CH_A_LO : ifs_pkg::CH_A_UP) + 8'(v - 10);
  endfunction

  // Well-formed field: blanks, sign, prefix, digits, terminator
  task automatic send_field();
    logic [1:0] radix;
    int         k;
    int         n;
    repeat ($urandom_range(0, 2)) offer_char(pick_blank(), 1'b0);
    k = $urandom_range(0, 2);
    if (k == 0) offer_char(ifs_pkg::CH_PLUS, 1'b0);
    else if (k == 1) offer_char(ifs_pkg::CH_MINUS, 1'b0);
    radix = (cur_base == ifs_pkg::BASE_AUTO) ? ifs_pkg::BASE_DEC : cur_base;
    k = $urandom_range(0, 7);
    if (k < 2) begin
      offer_char(ifs_pkg::CH_ZERO, 1'b0);
      offer_char((k == 0) ? ifs_pkg::CH_X_LO : ifs_pkg::CH_X_UP, 1'b0);
      if (cur_base == ifs_pkg::BASE_AUTO || cur_base == ifs_pkg::BASE_HEX)
        radix = ifs_pkg::BASE_HEX;
    end else if (k == 2) begin
      offer_char(ifs_pkg::CH_ZERO, 1'b0);
      if (cur_base == ifs_pkg::BASE_AUTO) radix = ifs_pkg::BASE_OCT;
    end
    n = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 24) : $urandom_range(0, 6);
    repeat (n) offer_char(pick_digit(radix), 1'b0);
    k = $urandom_range(0, 9);
    if (k < 3) offer_end();
    else if (k < 6) offer_char(pick_blank(), 1'b0);
    else if (k < 8) send_text(",");
    else offer_char(8'($urandom), 1'b0);
  endtask

  // Stimulus and verdict
  initial begin
    string stoppers;
    int    phase_start;
    int    k;
    stoppers = ",;z*";
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings (decimal, signed, width cap, four bytes)
    offer_end();
    send_text(" \t");
    offer_char(ifs_pkg::CH_CR, 1'b0);
    send_text("-79a");
    send_text("+");
    offer_end();
    finish_phase();

    // directed: prefixes, lone zero, unsigned negation into one byte
    set_config(ifs_pkg::BASE_AUTO, 1'b0, 6'd0, ifs_pkg::SZ_BYTE);
    send_text("0xg08-1");
    offer_end();
    finish_phase();

    // directed: width of two in hex, sign then a non-digit
    set_config(ifs_pkg::BASE_HEX, 1'b1, 6'd2, ifs_pkg::SZ_DWORD);
    send_text("0XFf-");
    offer_char(8'hFF, 1'b0);
    finish_phase();

    // random phases, extremes of the settings first
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: set_config(ifs_pkg::BASE_AUTO, 1'b1, 6'd0,  ifs_pkg::SZ_BYTE);
        1: set_config(ifs_pkg::BASE_OCT,  1'b0, 6'd63, ifs_pkg::SZ_HALF);
        2: set_config(ifs_pkg::BASE_DEC,  1'b1, 6'd1,  ifs_pkg::SZ_WORD);
        3: set_config(ifs_pkg::BASE_HEX,  1'b0, 6'd2,  ifs_pkg::SZ_DWORD);
        4: set_config(ifs_pkg::BASE_DEC,  1'b0, 6'd0,  ifs_pkg::SZ_DWORD);
        5: set_config(ifs_pkg::BASE_HEX,  1'b1, 6'd0,  ifs_pkg::SZ_DWORD);
        default: begin
          k = $urandom_range(0, 3);
          set_config(2'($urandom), 1'($urandom),
                     (k == 0) ? 6'd0 : (k == 1) ? 6'd63 :
                     (k == 2) ? 6'($urandom_range(1, 5)) : 6'($urandom_range(1, 63)),
                     2'($urandom));
        end
      endcase
      // receiver holds off while short fields keep coming, filling the block
      if (p == 4) begin
        hold_off_count <= hold_off_count + 1;
        repeat (40) offer_char(stoppers[$urandom_range(0, 3)], 1'b0);
      end
      phase_start = chars_sent;
      while (chars_sent - phase_start < PHASE_CHARS) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 4))
            offer_char(8'($urandom), $urandom_range(0, 15) == 0);
        end else begin
          send_field();
        end
      end
      finish_phase();
    end

    if (mismatch_count == 0 && pending_results == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/ifs_pkg.sv
hw/rtl/ifs_scan.sv
hw/rtl/ifs_format.sv
hw/rtl/integer_field_scanner.sv
tb/sv/integer_field_scanner_checker.sv
tb/sv/integer_field_scanner_test.sv
